// ===== design/spr_pkg.sv =====
// Shared types and constants for the source post rate limiter.
// No dependencies; used by the slot cells and the top level.
package spr_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_MARK  = 1'b1;

    // Query record handed from cell to cell (the slot index travels beside it).
    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] addr;
        logic [31:0] now;
        logic        found;
        logic [31:0] best_time;
    } spr_rec_t;

    // Write-back of a mark beat, broadcast to every cell.
    typedef struct packed {
        logic        en;
        logic [31:0] addr;
        logic [31:0] stamp;
    } spr_wr_t;

endpackage

// ===== design/spr_cell.sv =====
// One table slot of the rate limiter: holds an (address, timestamp) pair
// and updates the passing query record. Depends on spr_pkg.
module spr_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold,
    input  spr_pkg::spr_rec_t   rec_in,
    input  logic [IDX_W-1:0]    pick_in,
    output spr_pkg::spr_rec_t   rec_out,
    output logic [IDX_W-1:0]    pick_out,
    input  spr_pkg::spr_wr_t    wr,
    input  logic [IDX_W-1:0]    wr_idx
);

    logic [31:0]       slot_addr_reg;
    logic [31:0]       slot_time_reg;
    spr_pkg::spr_rec_t rec_reg;
    spr_pkg::spr_rec_t rec_next;
    logic [IDX_W-1:0]  pick_reg;
    logic [IDX_W-1:0]  pick_next;
    logic              wr_hit;

    assign wr_hit = wr.en && (wr_idx == IDX_W'(INDEX));

    always_comb
    begin
        rec_next  = rec_in;
        pick_next = pick_in;
        if (rec_in.op == spr_pkg::OP_MARK)
        begin
            // keep the lowest slot among the oldest
            if (rec_in.best_time > slot_time_reg)
            begin
                rec_next.best_time = slot_time_reg;
                pick_next          = IDX_W'(INDEX);
            end
        end
        else if (!rec_in.found && (slot_addr_reg == rec_in.addr))
        begin
            rec_next.found     = 1'b1;
            rec_next.best_time = slot_time_reg;
            pick_next          = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_addr_reg <= '0;
            slot_time_reg <= '0;
            rec_reg       <= '0;
            pick_reg      <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                slot_addr_reg <= wr.addr;
                slot_time_reg <= wr.stamp;
            end
            if (!hold)
            begin
                rec_reg  <= rec_next;
                pick_reg <= pick_next;
            end
        end
    end

    assign rec_out  = rec_reg;
    assign pick_out = pick_reg;

endmodule

// ===== design/source_post_rate_limit_table.sv =====
// Top level of the per-source post rate limiter: a row of slot cells,
// verdict logic and the output register. Depends on spr_pkg and spr_cell.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: op; s_tdata: source_addr, now
//  m_      | out | m_tvalid/m_tready  | m_tdata: post_allowed, match_found, slot_index
//  cfg_    | in  | cfg_we             | cfg_wdata: min_interval
//
// An accepted beat walks the cell row, one slot per cycle while no stall
// holds the row, and its result is registered in the output register as it
// leaves the row; only then can the next beat be taken, so one beat is in
// the row at a time. A mark writes its slot at the edge its result enters
// the output register. While a result waits on m_tready the next beat may
// still enter; it holds at the row's end until the output register frees.
// Reset clears all slots to address 0, time 0 and min_interval to 0 at once.
module source_post_rate_limit_table #(
    parameter int SLOTS = spr_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] source_addr, [63:32] now
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] post_allowed, [1] match_found, [5:2] slot_index
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata  // [31:0] min_interval
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    spr_pkg::spr_rec_t rec  [0:SLOTS];
    logic [IDX_W-1:0]  pick [0:SLOTS];
    spr_pkg::spr_rec_t last;
    spr_pkg::spr_wr_t  wr;

    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;
    logic [31:0] min_interval_reg;
    logic        accept;
    logic        stall;
    logic        move;
    logic        refused;
    logic [32:0] until_sum;
    logic [IDX_W+3:0] pick_ext;
    logic        allowed;
    logic        match;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    // Entry record: mark starts from the largest time so slot 0 is taken first
    always_comb
    begin
        rec[0].valid     = accept;
        rec[0].op        = s_tuser;
        rec[0].addr      = s_tdata[31:0];
        rec[0].now       = s_tdata[63:32];
        rec[0].found     = 1'b0;
        rec[0].best_time = '1;
        pick[0]          = '0;
    end

    assign last  = rec[SLOTS];
    assign stall = last.valid && out_valid_reg && !m_tready;
    assign move  = last.valid && !stall;

    // Mark write-back, one beat only, at the edge the result is registered
    assign wr.en    = move && (last.op == spr_pkg::OP_MARK);
    assign wr.addr  = last.addr;
    assign wr.stamp = last.now;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            spr_cell #(
                .INDEX (g),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .hold     (stall),
                .rec_in   (rec[g]),
                .pick_in  (pick[g]),
                .rec_out  (rec[g+1]),
                .pick_out (pick[g+1]),
                .wr       (wr),
                .wr_idx   (pick[SLOTS])
            );
        end
    endgenerate

    // Verdict: refuse while the matched stamp is in the past but still inside
    // the interval; the sum is 33 bits wide so it never wraps
    assign until_sum = {1'b0, last.best_time} + {1'b0, min_interval_reg};
    assign refused   = last.found && (until_sum > {1'b0, last.now})
                       && (last.best_time < last.now);
    assign allowed   = (last.op == spr_pkg::OP_MARK) ? 1'b1 : !refused;
    assign match     = (last.op == spr_pkg::OP_MARK) ? 1'b0 : last.found;
    assign pick_ext  = {4'b0000, pick[SLOTS]};

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (move)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            min_interval_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                min_interval_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= {2'b00, pick_ext[3:0], match, allowed};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/spr_checker.sv =====
// Port-level checks for the rate limiter, bound to the top level.
// Depends only on the top level's ports.
module spr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one beat in the row at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // a result never appears in the cycle after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // without a matching slot the post is always allowed
    a_nomatch_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("refusal without a matching slot");

endmodule

bind source_post_rate_limit_table spr_checker u_spr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/source_post_rate_limit_table_test.sv =====
// Self-checking bench for source_post_rate_limit_table: a queue-fed stream driver,
// a random-stall receiver and a monitor that compares every result beat against
// an in-bench slot table predictor. Depends on spr_pkg and the block's RTL only.
`timescale 1ns / 100ps

module source_post_rate_limit_table_test;

    localparam int SLOT_COUNT = spr_pkg::SLOTS_DEFAULT;
    // Cycles to let pass after the last result before touching the register.
    localparam int SETTLE_CYCLES = SLOT_COUNT + 4;

    // One request beat as the bench sees it.
    typedef struct packed {
        logic        op;
        logic [31:0] source_addr;
        logic [31:0] now;
    } post_beat_t;

    // One verdict beat as the block returns it.
    typedef struct packed {
        logic       post_allowed;
        logic       match_found;
        logic [3:0] slot_index;
    } verdict_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;      // [31:0] source_addr, [63:32] now
    logic        s_tuser   = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;             // [0] post_allowed, [1] match_found, [5:2] slot_index
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;      // [31:0] min_interval

    // Beats waiting for the driver, and verdicts waiting for the monitor.
    post_beat_t  beat_q[$];
    verdict_t    verdict_q[$];

    // Predictor copy of the block's state and register.
    logic [31:0] addr_tab [SLOT_COUNT];
    logic [31:0] stamp_tab[SLOT_COUNT];
    logic [31:0] gap_secs;

    // Random stimulus state.
    logic [31:0] addr_pool[24];
    logic [31:0] sim_clock;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors        = 0;
    int unsigned n_checks      = 0;
    int unsigned n_marks       = 0;
    int unsigned n_refused     = 0;
    int unsigned n_matched     = 0;
    int unsigned n_settings    = 0;

    source_post_rate_limit_table #(
        .SLOTS(SLOT_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    // Predict the verdict of one accepted beat and apply its effect on the table.
    task automatic predict_verdict(input post_beat_t b);
        verdict_t    v;
        int unsigned pick;
        logic [32:0] until_t;
        pick = 0;
        v.post_allowed = 1'b1;
        v.match_found  = 1'b0;
        if (b.op == spr_pkg::OP_CHECK)
        begin
            // First slot holding this address wins.
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                if (!v.match_found && addr_tab[k] == b.source_addr)
                begin
                    pick = k;
                    v.match_found = 1'b1;
                end
            end
            if (v.match_found)
            begin
                // 33-bit sum: a stamp near the top never wraps into the past.
                until_t = {1'b0, stamp_tab[pick]} + {1'b0, gap_secs};
                if (until_t > {1'b0, b.now} && stamp_tab[pick] < b.now)
                    v.post_allowed = 1'b0;
            end
            n_checks++;
        end
        else
        begin
            // Evict the oldest stamp; the lowest slot wins a tie.
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                if (stamp_tab[pick] > stamp_tab[k])
                    pick = k;
            end
            addr_tab[pick]  = b.source_addr;
            stamp_tab[pick] = b.now;
            n_marks++;
        end
        v.slot_index = pick[3:0];
        verdict_q.push_back(v);
    endtask

    // Driver: advance the beat queue on each accepted beat, hold an offered
    // beat until taken, and idle at random between beats.
    always @(posedge clk)
    begin
        bit took;
        took = 1'b0;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            took = s_tvalid && s_tready;
            if (took)
                predict_verdict(beat_q.pop_front());
            if (s_tvalid && !took)
            begin
                // hold the offered beat
            end
            else if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= beat_q[0].op;
                s_tdata  <= {beat_q[0].now, beat_q[0].source_addr};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result side at the current idle rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.post_allowed)
                begin
                    $display("%0t: post_allowed expected %0b got %0b",
                             $time, want.post_allowed, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.match_found)
                begin
                    $display("%0t: match_found expected %0b got %0b",
                             $time, want.match_found, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[5:2] !== want.slot_index)
                begin
                    $display("%0t: slot_index expected %0d got %0d",
                             $time, want.slot_index, m_tdata[5:2]);
                    errors++;
                end
                if (!want.post_allowed)
                    n_refused++;
                if (want.match_found)
                    n_matched++;
            end
        end
    end

    task automatic queue_beat(input logic op, input logic [31:0] addr, input logic [31:0] now);
        post_beat_t b;
        b.op          = op;
        b.source_addr = addr;
        b.now         = now;
        beat_q.push_back(b);
    endtask

    // Wait until every beat is taken and every verdict returned, then let the
    // row drain before anything else happens.
    task automatic drain_all();
        while (beat_q.size() != 0 || verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write min_interval; only called with the block idle.
    task automatic write_gap(input logic [31:0] secs);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= secs;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_secs = secs;
        n_settings++;
        @(negedge clk);
    endtask

    // Fill the address pool: a few fixed corners plus random sources.
    task automatic reseed_pool();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 24; k++)
            addr_pool[k] = $urandom;
    endtask

    // Queue random beats: mostly a small pool of sources posting close to a
    // slowly advancing clock, so slots get matched, refused and evicted;
    // the rest are stray sources and arbitrary times.
    task automatic queue_random(input int unsigned count);
        logic        op;
        logic [31:0] addr;
        logic [31:0] now;
        int unsigned roll;
        for (int unsigned n = 0; n < count; n++)
        begin
            sim_clock = sim_clock + $urandom_range(12);
            op   = ($urandom_range(99) < 40) ? spr_pkg::OP_MARK : spr_pkg::OP_CHECK;
            addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(23)] : $urandom;
            roll = $urandom_range(99);
            if (roll < 70)
                now = sim_clock + $urandom_range(8);
            else if (roll < 85)
                now = sim_clock - $urandom_range(40);
            else
                now = $urandom;
            queue_beat(op, addr, now);
        end
    endtask

    initial
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            addr_tab[k]  = '0;
            stamp_tab[k] = '0;
        end
        gap_secs = '0;

        // Hold reset, then release it once.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, register still at its reset value of zero.
        queue_beat(spr_pkg::OP_CHECK, 32'h0000_0000, 32'h0000_0000);  // zero address, now zero
        queue_beat(spr_pkg::OP_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_beat(spr_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'h0000_0005);  // no match anywhere
        queue_beat(spr_pkg::OP_MARK,  32'h0A00_0001, 32'd100);        // tie on oldest: slot 0
        queue_beat(spr_pkg::OP_MARK,  32'h0A00_0002, 32'd100);
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd120);        // zero interval: allowed
        drain_all();

        write_gap(32'd50);
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd120);        // inside the window
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd150);        // window just closed
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd149);
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd100);        // stamp equals now
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0001, 32'd99);         // clock went backward
        queue_beat(spr_pkg::OP_CHECK, 32'h0000_0000, 32'd1);
        queue_beat(spr_pkg::OP_MARK,  32'h0A00_0001, 32'd300);        // same source again
        drain_all();

        write_gap(32'hFFFF_FFFF);
        queue_beat(spr_pkg::OP_MARK,  32'hC0A8_0001, 32'hFFFF_FFF0);
        queue_beat(spr_pkg::OP_CHECK, 32'hC0A8_0001, 32'hFFFF_FFFF);  // sum above 32 bits
        queue_beat(spr_pkg::OP_CHECK, 32'hC0A8_0001, 32'hFFFF_FFF0);
        queue_beat(spr_pkg::OP_CHECK, 32'hC0A8_0001, 32'h0000_0000);
        queue_beat(spr_pkg::OP_CHECK, 32'h0A00_0002, 32'hFFFF_FFFF);
        queue_beat(spr_pkg::OP_MARK,  32'hFFFF_FFFF, 32'h0000_0000);
        queue_beat(spr_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_beat(spr_pkg::OP_CHECK, 32'h0000_0000, 32'd7);
        queue_beat(spr_pkg::OP_MARK,  32'h0000_0000, 32'hFFFF_FFFF);
        queue_beat(spr_pkg::OP_CHECK, 32'h0000_0000, 32'd3);
        drain_all();

        // Random phase 1: short interval, sender rarely idle, receiver mostly stalled.
        // Split in two with a full drain between to pause the sender.
        write_gap(32'd25);
        reseed_pool();
        sim_clock     = $urandom;
        send_idle_pct = 10;
        recv_idle_pct = 83;
        queue_random(225);
        drain_all();
        queue_random(225);
        drain_all();

        // Random phase 2: widest interval, roles of idling swapped.
        write_gap(32'hFFFF_FFFF);
        reseed_pool();
        sim_clock     = 32'hFFFF_FF00;   // walk the clock through the wrap
        send_idle_pct = 83;
        recv_idle_pct = 10;
        queue_random(450);
        drain_all();

        // Random phase 3: zero interval, nobody idles.
        write_gap(32'd0);
        reseed_pool();
        sim_clock     = $urandom;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(450);
        drain_all();

        // Random phase 4: random moderate interval, still no idling.
        write_gap($urandom_range(200, 1));
        reseed_pool();
        sim_clock = $urandom;
        queue_random(450);
        drain_all();

        $display("Covered %0d checks (%0d matched, %0d refused) and %0d marks",
                 n_checks, n_matched, n_refused, n_marks);
        $display("over %0d interval settings with idle and stall mixes on both sides.",
                 n_settings);
        if (errors == 0)
            $display("[source_post_rate_limit_table] OK");
        else
            $display("[source_post_rate_limit_table] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("[source_post_rate_limit_table] ERROR");
        $finish;
    end

endmodule
